/* design/wsp_pkg.sv */
// Package for the per-channel moving-sum peak detector.
// Field widths and register reset value; no dependencies.
package wsp_pkg;

	localparam int CH_FIELD_W   = 4;
	localparam int SAMPLE_W     = 18;
	localparam int SUM_W        = 21;
	localparam int SLOT_FIELD_W = 7;
	localparam int WIN_W        = 4;

	localparam logic [WIN_W-1:0] WIN_RESET = 4'd5;

endpackage

/* design/wsp_if.sv */
// Valid/ready channel interfaces for sample beats and result beats.
// Uses widths from wsp_pkg.
interface wsp_in_if;
	logic                             valid;
	logic                             ready;
	logic [wsp_pkg::CH_FIELD_W-1:0]   channel;
	logic [wsp_pkg::SAMPLE_W-1:0]     sample;
	logic                             close_window;

	modport source (output valid, output channel, output sample, output close_window,
		input ready);
	modport sink (input valid, input channel, input sample, input close_window,
		output ready);
endinterface

interface wsp_out_if;
	logic                              valid;
	logic                              ready;
	logic [wsp_pkg::CH_FIELD_W-1:0]    out_channel;
	logic [wsp_pkg::SLOT_FIELD_W-1:0]  slot_index;
	logic [wsp_pkg::SAMPLE_W-1:0]      peak_average;

	modport source (output valid, output out_channel, output slot_index,
		output peak_average, input ready);
	modport sink (input valid, input out_channel, input slot_index,
		input peak_average, output ready);
endinterface

/* design/wsp_divider.sv */
// Restoring divider, one quotient bit per cycle over the window sum width.
// Uses wsp_pkg for the dividend width.
module wsp_divider #(
	parameter int DIV_W = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [wsp_pkg::SUM_W-1:0] dividend,
	input  logic [DIV_W-1:0]          divisor,
	output logic                      done,
	output logic [wsp_pkg::SUM_W-1:0] quotient
);
	localparam int SW    = wsp_pkg::SUM_W;
	localparam int CNT_W = $clog2(SW + 1);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] div_q;
	logic [SW-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[SW-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(SW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[SW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

/* design/window_sum_peak_per_channel.sv */
// Per-channel moving-sum peak detector, top level.
// A closing sample beat passes through the history read loop and the 21-step shared
// divider before its result beat is loaded.
// Samples are taken one at a time: in_ready stays low until the previous beat is finished.
// Reset: asynchronous active-low arst_n; valid bits and fill counts make history and
// peaks read as zero, slot counter clears, window_len returns to 5.
module window_sum_peak_per_channel #(
	parameter int CHANNELS   = 16,
	parameter int MAX_WINDOW = 8,
	parameter int CUP_SLOTS  = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [wsp_pkg::WIN_W-1:0]  cfg_wdata,
	wsp_in_if.sink                     in_ch,
	wsp_out_if.source                  out_ch
);
	localparam int SW     = wsp_pkg::SUM_W;
	localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int IW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LW     = $clog2(MAX_WINDOW + 1);
	localparam int HD     = CHANNELS * MAX_WINDOW;
	localparam int HAW    = (HD > 1) ? $clog2(HD) : 1;
	localparam int SLOT_W = (CUP_SLOTS > 1) ? $clog2(CUP_SLOTS) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_META = 3'd1;
	localparam logic [2:0] S_SUM  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	typedef struct packed {
		logic [IW-1:0] ptr;
		logic [LW-1:0] fill;
		logic [SW-1:0] peak;
	} meta_t;

	logic [2:0]                          state_q;
	logic [wsp_pkg::WIN_W-1:0]           wl_q;
	logic [wsp_pkg::CH_FIELD_W-1:0]      ch_q;
	logic [wsp_pkg::SAMPLE_W-1:0]        smp_q;
	logic                                close_q;
	logic [CHANNELS-1:0]                 chv_q;
	logic [SLOT_W-1:0]                   slot_q;

	meta_t                               meta_mem [CHANNELS];
	meta_t                               meta_rd_q;
	logic [wsp_pkg::SAMPLE_W-1:0]        hist_mem [HD];
	logic [wsp_pkg::SAMPLE_W-1:0]        hist_rd_q;

	logic [IW-1:0]                       ptr_q;
	logic [LW-1:0]                       fill_q;
	logic [SW-1:0]                       peak_q;
	logic [SW-1:0]                       sum_q;
	logic [LW-1:0]                       len_q;
	logic [LW-1:0]                       k_q;
	logic                                pend_q;
	logic                                pend_ok_q;

	logic                                out_valid_q;
	logic [wsp_pkg::CH_FIELD_W-1:0]      out_chan_q;
	logic [wsp_pkg::SLOT_FIELD_W-1:0]    out_slot_q;
	logic [wsp_pkg::SAMPLE_W-1:0]        out_avg_q;

	logic                                accept;
	logic                                ch_ok;
	logic [CW-1:0]                       chi;
	meta_t                               meta_cur;
	logic [LW-1:0]                       eff_len;
	logic [LW-1:0]                       fill_n;
	logic [IW-1:0]                       ptr_n;
	logic [IW-1:0]                       age_idx;
	logic                                sum_done;
	logic [SW-1:0]                       new_peak;
	logic                                div_start;
	logic                                div_done;
	logic [SW-1:0]                       div_quo;
	logic                                out_load;

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign ch_ok       = 32'(in_ch.channel) < CHANNELS;
	assign chi         = CW'(ch_q);

	assign meta_cur = chv_q[chi] ? meta_rd_q : '0;

	always_comb begin
		if (wl_q == '0) begin
			eff_len = LW'(1);
		end else if (32'(wl_q) > MAX_WINDOW) begin
			eff_len = LW'(MAX_WINDOW);
		end else begin
			eff_len = LW'(wl_q);
		end
	end

	assign fill_n = (32'(meta_cur.fill) < MAX_WINDOW) ? meta_cur.fill + 1'b1 : meta_cur.fill;
	assign ptr_n  = (32'(ptr_q) == MAX_WINDOW - 1) ? '0 : ptr_q + 1'b1;
	assign age_idx = (ptr_q >= IW'(k_q)) ? IW'(32'(ptr_q) - 32'(k_q))
		: IW'(32'(ptr_q) + MAX_WINDOW - 32'(k_q));

	assign sum_done  = (state_q == S_SUM) && (k_q >= len_q) && !pend_q;
	assign new_peak  = (sum_q > peak_q) ? sum_q : peak_q;
	assign div_start = sum_done && close_q;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ch.ready);

	wsp_divider #(
		.DIV_W(LW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (new_peak),
		.divisor  (len_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wl_q        <= wsp_pkg::WIN_RESET;
			chv_q       <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				wl_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && ch_ok) begin
						state_q <= S_META;
					end
				end
				S_META: begin
					pend_q  <= 1'b0;
					state_q <= S_SUM;
				end
				S_SUM: begin
					pend_q <= (k_q < len_q);
					if (sum_done) begin
						chv_q[chi] <= 1'b1;
						state_q    <= close_q ? S_DIV : S_IDLE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
						if (32'(ch_q) == CHANNELS - 1) begin
							slot_q <= (32'(slot_q) == CUP_SLOTS - 1) ? '0 : slot_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q      <= in_ch.channel;
			smp_q     <= in_ch.sample;
			close_q   <= in_ch.close_window;
			meta_rd_q <= meta_mem[CW'(in_ch.channel)];
		end
		if (state_q == S_META) begin
			hist_mem[HAW'(32'(chi) * MAX_WINDOW + 32'(meta_cur.ptr))] <= smp_q;
			ptr_q  <= meta_cur.ptr;
			fill_q <= fill_n;
			peak_q <= meta_cur.peak;
			sum_q  <= SW'(smp_q);
			len_q  <= eff_len;
			k_q    <= LW'(1);
		end
		if (state_q == S_SUM) begin
			if (k_q < len_q) begin
				hist_rd_q <= hist_mem[HAW'(32'(chi) * MAX_WINDOW + 32'(age_idx))];
				pend_ok_q <= k_q < fill_q;
				k_q       <= k_q + 1'b1;
			end
			if (pend_q && pend_ok_q) begin
				sum_q <= sum_q + SW'(hist_rd_q);
			end
		end
		if (sum_done) begin
			meta_mem[chi] <= '{ptr: ptr_n, fill: fill_q, peak: close_q ? '0 : new_peak};
		end
		if (out_load) begin
			out_chan_q <= ch_q;
			out_slot_q <= wsp_pkg::SLOT_FIELD_W'(slot_q);
			out_avg_q  <= div_quo[wsp_pkg::SAMPLE_W-1:0];
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_channel  = out_chan_q;
	assign out_ch.slot_index   = out_slot_q;
	assign out_ch.peak_average = out_avg_q;
endmodule

/* design/wsp_checker.sv */
// Port-level checks for the peak detector top level.
// Bound to window_sum_peak_per_channel; uses wsp_pkg widths.
module wsp_checker #(
	parameter int CHANNELS = 16
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic [wsp_pkg::CH_FIELD_W-1:0]   in_channel,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [wsp_pkg::CH_FIELD_W-1:0]   out_channel,
	input logic [wsp_pkg::SLOT_FIELD_W-1:0] slot_index,
	input logic [wsp_pkg::SAMPLE_W-1:0]     peak_average
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_channel)
			&& $stable(slot_index) && $stable(peak_average))
		else $error("result beat changed while stalled");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (32'(in_channel) < CHANNELS) |=> !in_ready)
		else $error("sample taken while previous beat in progress");

	a_out_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_channel) < CHANNELS)
		else $error("result for nonexistent channel");

	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a sample in progress");
endmodule

bind window_sum_peak_per_channel wsp_checker #(
	.CHANNELS(CHANNELS)
) u_wsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.in_channel   (in_ch.channel),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_channel  (out_ch.out_channel),
	.slot_index   (out_ch.slot_index),
	.peak_average (out_ch.peak_average)
);
